[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the blend pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/cabc_pkg.sv]
// ----------------------------------------------------------------------------
// Coverage blend package
// Register indexes, field widths and the truncating divide by 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cabc_pkg;

    localparam int CHAN_W  = 8;
    localparam int COORD_W = 16;
    localparam int PIXEL_W = 32;
    localparam int PROD_W  = 2 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_RED      = 3'd0,
        CFG_COLOR_GREEN    = 3'd1,
        CFG_COLOR_BLUE     = 3'd2,
        CFG_COLOR_ALPHA    = 3'd3,
        CFG_SURFACE_WIDTH  = 3'd4,
        CFG_SURFACE_HEIGHT = 3'd5
    } t_cfg_idx;

    // Exact floor(x / 255) for every x below 65280.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

[hdl/coverage_alpha_blend_clip.sv]
// ----------------------------------------------------------------------------
// Coverage alpha blend with clipping
// Blends the text color, scaled by glyph coverage, source-over onto a pixel.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the output is not stalled
// and passes it through four register stages (clip and alpha product,
// effective alpha, channel products, divide and sum). Backpressure on the
// output propagates back through the stages in the same cycle, so a stall
// loses no beat. Configuration writes must be made while the pipeline is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coverage_alpha_blend_clip (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [cabc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cabc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pixel_x [15:0], pixel_y [31:16], coverage [39:32], dest_pixel [71:40]
    input  logic [71:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // blended_pixel [31:0]
    output logic [31:0]                        m_axis_tdata,
    // write_enable [0]
    output logic                               m_axis_tuser
);

    localparam int CW = cabc_pkg::CHAN_W;
    localparam int PW = cabc_pkg::PROD_W;

    logic [CW-1:0] r_color_red, r_color_green, r_color_blue, r_color_alpha;
    logic [cabc_pkg::COORD_W-1:0] r_surf_w, r_surf_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_red   <= '0;
            r_color_green <= '0;
            r_color_blue  <= '0;
            r_color_alpha <= '0;
            r_surf_w      <= '0;
            r_surf_h      <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cabc_pkg::CFG_COLOR_RED:      r_color_red   <= i_cfg_wdata[CW-1:0];
                cabc_pkg::CFG_COLOR_GREEN:    r_color_green <= i_cfg_wdata[CW-1:0];
                cabc_pkg::CFG_COLOR_BLUE:     r_color_blue  <= i_cfg_wdata[CW-1:0];
                cabc_pkg::CFG_COLOR_ALPHA:    r_color_alpha <= i_cfg_wdata[CW-1:0];
                cabc_pkg::CFG_SURFACE_WIDTH:  r_surf_w      <= i_cfg_wdata;
                cabc_pkg::CFG_SURFACE_HEIGHT: r_surf_h      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [cabc_pkg::COORD_W-1:0] in_x, in_y;
    logic [CW-1:0]                in_cov;
    logic [cabc_pkg::PIXEL_W-1:0] in_dst;

    assign in_x   = s_axis_tdata[15:0];
    assign in_y   = s_axis_tdata[31:16];
    assign in_cov = s_axis_tdata[39:32];
    assign in_dst = s_axis_tdata[71:40];

    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: clip and alpha times coverage.
    logic          r_s1_valid, r_s1_ok;
    logic [PW-1:0] r_s1_prod;
    logic [31:0]   r_s1_dst;

    // Stage 2: effective alpha.
    logic          r_s2_valid, r_s2_we;
    logic [CW-1:0] r_s2_sa, r_s2_ia;
    logic [31:0]   r_s2_dst;

    // Stage 3: channel products.
    logic          r_s3_valid, r_s3_we;
    logic [CW-1:0] r_s3_sa;
    logic [PW-1:0] r_s3_pr, r_s3_pg, r_s3_pb;
    logic [PW-1:0] r_s3_dr, r_s3_dg, r_s3_db, r_s3_da;
    logic [31:0]   r_s3_dst;

    // Stage 4: output register.
    logic          r_s4_valid, r_s4_we;
    logic [31:0]   r_s4_pixel;

    logic [CW-1:0] n_blue, n_green, n_red, n_alpha;
    logic [CW-1:0] n_sa;

    assign rdy4 = !r_s4_valid || m_axis_tready;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;
    assign s_axis_tready = rdy1;

    assign n_sa    = cabc_pkg::div255(r_s1_prod);
    assign n_blue  = cabc_pkg::div255(r_s3_pb) + cabc_pkg::div255(r_s3_db);
    assign n_green = cabc_pkg::div255(r_s3_pg) + cabc_pkg::div255(r_s3_dg);
    assign n_red   = cabc_pkg::div255(r_s3_pr) + cabc_pkg::div255(r_s3_dr);
    assign n_alpha = r_s3_sa + cabc_pkg::div255(r_s3_da);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= s_axis_tvalid;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
            if (rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_ok   <= (in_x < r_surf_w) && (in_y < r_surf_h) && (in_cov != '0);
            r_s1_prod <= r_color_alpha * in_cov;
            r_s1_dst  <= in_dst;
        end
        if (rdy2) begin
            r_s2_sa  <= n_sa;
            r_s2_ia  <= cabc_pkg::CHAN_MAX - n_sa;
            r_s2_we  <= r_s1_ok && (n_sa != '0);
            r_s2_dst <= r_s1_dst;
        end
        if (rdy3) begin
            r_s3_sa  <= r_s2_sa;
            r_s3_we  <= r_s2_we;
            r_s3_dst <= r_s2_dst;
            r_s3_pr  <= r_color_red   * r_s2_sa;
            r_s3_pg  <= r_color_green * r_s2_sa;
            r_s3_pb  <= r_color_blue  * r_s2_sa;
            r_s3_db  <= r_s2_dst[7:0]   * r_s2_ia;
            r_s3_dg  <= r_s2_dst[15:8]  * r_s2_ia;
            r_s3_dr  <= r_s2_dst[23:16] * r_s2_ia;
            r_s3_da  <= r_s2_dst[31:24] * r_s2_ia;
        end
        if (rdy4) begin
            r_s4_we    <= r_s3_we;
            r_s4_pixel <= r_s3_we ? {n_alpha, n_red, n_green, n_blue} : r_s3_dst;
        end
    end

    assign m_axis_tvalid = r_s4_valid;
    assign m_axis_tdata  = r_s4_pixel;
    assign m_axis_tuser  = r_s4_we;

    `ASSERT_NEXT(a_alpha_floor, i_clk, i_rst_n, r_s3_valid && rdy4 && r_s3_we,
        m_axis_tdata[31:24] >= $past(r_s3_sa))
    `ASSERT_NEXT(a_pass_through, i_clk, i_rst_n, r_s3_valid && rdy4 && !r_s3_we,
        m_axis_tdata == $past(r_s3_dst) && !m_axis_tuser)
    `ASSERT_IMPL(a_zero_alpha_no_write, i_clk, i_rst_n, r_s2_valid && r_s2_sa == '0,
        !r_s2_we && r_s2_ia == cabc_pkg::CHAN_MAX)

endmodule
